[hw/rtl/sensor_min_max_calibrate_normalize_defines.svh]
`ifndef SENSOR_MIN_MAX_CALIBRATE_NORMALIZE_DEFINES_SVH
`define SENSOR_MIN_MAX_CALIBRATE_NORMALIZE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SMM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SMM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/smm_pkg.sv]
`default_nettype none

package smm_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR     = 2'd0,
      OP_CALIBRATE = 2'd1,
      OP_NORMALIZE = 2'd2,
      OP_LOAD      = 2'd3
   } smm_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_RESPOND
   } smm_state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic lookup;
      logic div_step;
   } smm_cmd_type;

   typedef struct packed {
      logic div_needed;
      logic div_last;
   } smm_stat_type;

   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned NORM_W   = 13;
   localparam int unsigned INDEX_W  = 4;
   localparam int unsigned STEP_W   = 4;

   localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'hFFF;
   localparam logic [NORM_W-1:0]   ONE_Q12    = 13'h1000;
   localparam logic [STEP_W-1:0]   DIV_LAST   = 4'd11;

endpackage

`default_nettype wire

[hw/rtl/smm_datapath.sv]
`default_nettype none

`include "sensor_min_max_calibrate_normalize_defines.svh"

module smm_datapath #(
   parameter int unsigned SENSOR_COUNT = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire smm_pkg::smm_cmd_type          cmd,
   output smm_pkg::smm_stat_type              stat,
   input  wire logic [1:0]                    req_op,
   input  wire logic [smm_pkg::INDEX_W-1:0]   req_sensor_index,
   input  wire logic [smm_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire logic [smm_pkg::SAMPLE_W-1:0]  req_load_low,
   input  wire logic [smm_pkg::SAMPLE_W-1:0]  req_load_high,
   output logic [smm_pkg::NORM_W-1:0]         norm_value,
   output logic [smm_pkg::SAMPLE_W-1:0]       low_bound,
   output logic [smm_pkg::SAMPLE_W-1:0]       high_bound,
   output logic [smm_pkg::SAMPLE_W-1:0]       midpoint,
   output logic                               calibrated,
   output logic                               bad_sensor
);

   localparam int unsigned IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

   smm_pkg::smm_op_type                op_ff;
   logic [smm_pkg::INDEX_W-1:0]        idx_ff;
   logic [smm_pkg::SAMPLE_W-1:0]       sample_ff;
   logic [smm_pkg::SAMPLE_W-1:0]       ld_lo_ff;
   logic [smm_pkg::SAMPLE_W-1:0]       ld_hi_ff;

   logic [smm_pkg::SAMPLE_W-1:0]       min_ff [SENSOR_COUNT];
   logic [smm_pkg::SAMPLE_W-1:0]       max_ff [SENSOR_COUNT];

   logic [smm_pkg::NORM_W-1:0]         norm_ff;
   logic [smm_pkg::SAMPLE_W-1:0]       lo_ff;
   logic [smm_pkg::SAMPLE_W-1:0]       hi_ff;
   logic [smm_pkg::SAMPLE_W-1:0]       mid_ff;
   logic                               cal_ff;
   logic                               bad_ff;
   logic [smm_pkg::SAMPLE_W-1:0]       rem_ff;
   logic [smm_pkg::SAMPLE_W-1:0]       den_ff;
   logic [smm_pkg::STEP_W-1:0]         step_ff;

   logic                               valid_c;
   logic [IDX_W-1:0]                   sel_c;
   logic [smm_pkg::SAMPLE_W-1:0]       rd_min_c;
   logic [smm_pkg::SAMPLE_W-1:0]       rd_max_c;
   logic                               cal_c;
   logic [smm_pkg::SAMPLE_W-1:0]       lo_c;
   logic [smm_pkg::SAMPLE_W-1:0]       hi_c;
   logic [smm_pkg::SAMPLE_W:0]         sum_c;
   logic                               is_norm_c;
   logic                               sat_c;
   logic                               div_needed_c;
   logic [smm_pkg::SAMPLE_W:0]         rem_sh_c;
   logic                               fits_c;
   logic [smm_pkg::SAMPLE_W:0]         rem_diff_c;

   always_comb begin
      valid_c  = {1'b0, idx_ff} < (smm_pkg::INDEX_W + 1)'(SENSOR_COUNT);
      sel_c    = idx_ff[IDX_W-1:0];
      rd_min_c = min_ff[sel_c];
      rd_max_c = max_ff[sel_c];
      cal_c    = valid_c && (rd_max_c > rd_min_c);
      lo_c     = cal_c ? rd_min_c : '0;
      hi_c     = cal_c ? rd_max_c : smm_pkg::FULL_SCALE;
      sum_c    = {1'b0, lo_c} + {1'b0, hi_c};
      // An uncalibrated sensor is scaled against the full converter range.
      is_norm_c    = (op_ff == smm_pkg::OP_NORMALIZE) && valid_c;
      sat_c        = is_norm_c && (sample_ff >= hi_c);
      div_needed_c = is_norm_c && (sample_ff > lo_c) && (sample_ff < hi_c);
      rem_sh_c   = {rem_ff, 1'b0};
      fits_c     = rem_sh_c >= {1'b0, den_ff};
      rem_diff_c = rem_sh_c - {1'b0, den_ff};
      stat.div_needed = div_needed_c;
      stat.div_last   = step_ff == smm_pkg::DIV_LAST;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= smm_pkg::smm_op_type'(req_op);
         idx_ff    <= req_sensor_index;
         sample_ff <= req_sample;
         ld_lo_ff  <= req_load_low;
         ld_hi_ff  <= req_load_high;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            min_ff[i] <= '0;
            max_ff[i] <= smm_pkg::FULL_SCALE;
         end
      end else if (cmd.update) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (op_ff == smm_pkg::OP_CLEAR) begin
               min_ff[i] <= smm_pkg::FULL_SCALE;
               max_ff[i] <= '0;
            end else if (valid_c && (sel_c == IDX_W'(i))) begin
               if (op_ff == smm_pkg::OP_CALIBRATE) begin
                  if (sample_ff < min_ff[i]) begin
                     min_ff[i] <= sample_ff;
                  end
                  if (sample_ff > max_ff[i]) begin
                     max_ff[i] <= sample_ff;
                  end
               end else if (op_ff == smm_pkg::OP_LOAD) begin
                  min_ff[i] <= ld_lo_ff;
                  max_ff[i] <= ld_hi_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff <= '0;
         cal_ff  <= 1'b0;
         bad_ff  <= 1'b0;
      end else if (cmd.lookup) begin
         norm_ff <= sat_c ? smm_pkg::ONE_Q12 : '0;
         cal_ff  <= cal_c;
         bad_ff  <= !valid_c;
      end else if (cmd.div_step) begin
         norm_ff <= {norm_ff[smm_pkg::NORM_W-2:0], fits_c};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         lo_ff   <= lo_c;
         hi_ff   <= hi_c;
         mid_ff  <= sum_c[smm_pkg::SAMPLE_W:1];
         rem_ff  <= sample_ff - lo_c;
         den_ff  <= hi_c - lo_c;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= fits_c ? rem_diff_c[smm_pkg::SAMPLE_W-1:0]
                           : rem_sh_c[smm_pkg::SAMPLE_W-1:0];
         step_ff <= step_ff + 1'b1;
      end
   end

   assign norm_value = norm_ff;
   assign low_bound  = lo_ff;
   assign high_bound = hi_ff;
   assign midpoint   = mid_ff;
   assign calibrated = cal_ff;
   assign bad_sensor = bad_ff;

   // The partial remainder must stay below the divisor for the quotient to fit.
   `SMM_ASSERT(a_rem_below_den, cmd.div_step |-> (rem_ff < den_ff), "remainder not below divisor")
   `SMM_ASSERT(a_norm_range, norm_ff <= smm_pkg::ONE_Q12, "normalised value above one")
   `SMM_ASSERT(a_bad_reports, (bad_ff && !cmd.div_step) |-> (!cal_ff && norm_ff == '0), "bad sensor beat reports calibration")

endmodule

`default_nettype wire

[hw/rtl/smm_controller.sv]
`default_nettype none

`include "sensor_min_max_calibrate_normalize_defines.svh"

module smm_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire smm_pkg::smm_stat_type stat,
   output smm_pkg::smm_cmd_type       cmd,
   output logic                       busy,
   output logic                       rsp_valid
);

   smm_pkg::smm_state_type state_ff;
   smm_pkg::smm_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smm_pkg::ST_IDLE: begin
            if (start) begin
               state_in = smm_pkg::ST_UPDATE;
            end
         end
         smm_pkg::ST_UPDATE: begin
            state_in = smm_pkg::ST_LOOKUP;
         end
         smm_pkg::ST_LOOKUP: begin
            state_in = stat.div_needed ? smm_pkg::ST_DIVIDE : smm_pkg::ST_RESPOND;
         end
         smm_pkg::ST_DIVIDE: begin
            if (stat.div_last) begin
               state_in = smm_pkg::ST_RESPOND;
            end
         end
         smm_pkg::ST_RESPOND: begin
            state_in = smm_pkg::ST_IDLE;
         end
         default: begin
            state_in = smm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         smm_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         smm_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         smm_pkg::ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         smm_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         smm_pkg::ST_RESPOND: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `SMM_ASSERT(a_accept_updates, (start && !busy) |=> (state_ff == smm_pkg::ST_UPDATE), "accepted beat not updating")
   `SMM_ASSERT(a_single_strobe, rsp_valid |=> (!rsp_valid && !busy), "result strobe longer than one cycle")
   `SMM_ASSERT(a_strobe_busy, rsp_valid |-> busy, "result strobe while idle")
   `SMM_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy, "busy after reset")

endmodule

`default_nettype wire

[hw/rtl/sensor_min_max_calibrate_normalize.sv]
// A result is strobed once its beat has passed the table update and lookup states and, when a
// normalise needs a division, 12 divider steps; the strobe state follows.
// A new beat can be accepted the cycle after the strobe and not while one is in flight,
// since the one-bit-per-cycle restoring divider is shared by all beats.
// Synchronous active-high reset returns to idle with every minimum 0 and maximum 4095.
// The receiver cannot stall; rsp_valid marks each result for one cycle only.
`default_nettype none

module sensor_min_max_calibrate_normalize #(
   parameter int unsigned SENSOR_COUNT = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_op,
   input  wire logic [smm_pkg::INDEX_W-1:0]   req_sensor_index,
   input  wire logic [smm_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire logic [smm_pkg::SAMPLE_W-1:0]  req_load_low,
   input  wire logic [smm_pkg::SAMPLE_W-1:0]  req_load_high,
   output logic                               rsp_valid,
   output logic [smm_pkg::NORM_W-1:0]         rsp_norm_value,
   output logic [smm_pkg::SAMPLE_W-1:0]       rsp_low_bound,
   output logic [smm_pkg::SAMPLE_W-1:0]       rsp_high_bound,
   output logic [smm_pkg::SAMPLE_W-1:0]       rsp_midpoint,
   output logic                               rsp_calibrated,
   output logic                               rsp_bad_sensor
);

   smm_pkg::smm_cmd_type  cmd;
   smm_pkg::smm_stat_type stat;

   smm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   smm_datapath #(
      .SENSOR_COUNT (SENSOR_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_op),
      .req_sensor_index (req_sensor_index),
      .req_sample       (req_sample),
      .req_load_low     (req_load_low),
      .req_load_high    (req_load_high),
      .norm_value       (rsp_norm_value),
      .low_bound        (rsp_low_bound),
      .high_bound       (rsp_high_bound),
      .midpoint         (rsp_midpoint),
      .calibrated       (rsp_calibrated),
      .bad_sensor       (rsp_bad_sensor)
   );

endmodule

`default_nettype wire

[tb/sensor_min_max_calibrate_normalize_checker.sv]
module sensor_min_max_calibrate_normalize_checker #(
   parameter int unsigned SENSOR_COUNT = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [1:0]                    req_op,
   input  logic [smm_pkg::INDEX_W-1:0]   req_sensor_index,
   input  logic [smm_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic [smm_pkg::SAMPLE_W-1:0]  req_load_low,
   input  logic [smm_pkg::SAMPLE_W-1:0]  req_load_high,
   input  logic                          rsp_valid,
   input  logic [smm_pkg::NORM_W-1:0]    rsp_norm_value,
   input  logic [smm_pkg::SAMPLE_W-1:0]  rsp_low_bound,
   input  logic [smm_pkg::SAMPLE_W-1:0]  rsp_high_bound,
   input  logic [smm_pkg::SAMPLE_W-1:0]  rsp_midpoint,
   input  logic                          rsp_calibrated,
   input  logic                          rsp_bad_sensor,
   output int unsigned                   fail_count,
   output int unsigned                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import smm_pkg::*;

   typedef struct packed {
      logic [NORM_W-1:0]   norm_value;
      logic [SAMPLE_W-1:0] low_bound;
      logic [SAMPLE_W-1:0] high_bound;
      logic [SAMPLE_W-1:0] midpoint;
      logic                calibrated;
      logic                bad_sensor;
   } bounds_report_type;

   logic [SAMPLE_W-1:0] min_tbl [SENSOR_COUNT];
   logic [SAMPLE_W-1:0] max_tbl [SENSOR_COUNT];
   bounds_report_type   expected_reports [$];
   int unsigned         mismatch_count = 0;

   function automatic bounds_report_type apply_sensor_cmd(
      smm_op_type          op,
      logic [INDEX_W-1:0]  idx,
      logic [SAMPLE_W-1:0] smp,
      logic [SAMPLE_W-1:0] ld_lo,
      logic [SAMPLE_W-1:0] ld_hi
   );
      bounds_report_type r;
      logic              in_range;
      int unsigned       quot;
      int                i;
      in_range = (idx < SENSOR_COUNT);
      r = '0;
      r.high_bound = FULL_SCALE;
      case (op)
         OP_CLEAR: begin
            for (i = 0; i < SENSOR_COUNT; i++) begin
               min_tbl[i] = FULL_SCALE;
               max_tbl[i] = '0;
            end
         end
         OP_CALIBRATE: begin
            if (in_range) begin
               if (smp < min_tbl[idx]) min_tbl[idx] = smp;
               if (smp > max_tbl[idx]) max_tbl[idx] = smp;
            end
         end
         OP_LOAD: begin
            if (in_range) begin
               min_tbl[idx] = ld_lo;
               max_tbl[idx] = ld_hi;
            end
         end
         default: ;
      endcase
      if (in_range && max_tbl[idx] > min_tbl[idx]) begin
         r.low_bound  = min_tbl[idx];
         r.high_bound = max_tbl[idx];
         r.calibrated = 1'b1;
      end
      // The division uses the effective bounds, so an uncalibrated sensor still
      // scales against the full converter range.
      if (op == OP_NORMALIZE && in_range && r.high_bound > r.low_bound
          && smp > r.low_bound) begin
         quot = ((32'(smp) - 32'(r.low_bound)) << 12)
                / (32'(r.high_bound) - 32'(r.low_bound));
         if (quot > ONE_Q12) quot = ONE_Q12;
         r.norm_value = quot[NORM_W-1:0];
      end
      r.midpoint   = SAMPLE_W'((13'(r.low_bound) + 13'(r.high_bound)) >> 1);
      r.bad_sensor = !in_range;
      return r;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      bounds_report_type want;
      int                i;
      if (reset) begin
         for (i = 0; i < SENSOR_COUNT; i++) begin
            min_tbl[i] = '0;
            max_tbl[i] = FULL_SCALE;
         end
         expected_reports.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_reports.size() == 0) begin
               $error("result beat arrived with no request outstanding");
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               check_field("norm_value", want.norm_value, rsp_norm_value);
               check_field("low_bound", want.low_bound, rsp_low_bound);
               check_field("high_bound", want.high_bound, rsp_high_bound);
               check_field("midpoint", want.midpoint, rsp_midpoint);
               check_field("calibrated", want.calibrated, rsp_calibrated);
               check_field("bad_sensor", want.bad_sensor, rsp_bad_sensor);
            end
         end
         if (start && !busy) begin
            expected_reports.push_back(apply_sensor_cmd(smm_op_type'(req_op),
               req_sensor_index, req_sample, req_load_low, req_load_high));
         end
      end
      pending    <= expected_reports.size();
      fail_count <= mismatch_count;
   end

endmodule

[tb/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import smm_pkg::*;

   localparam int unsigned SENSORS      = 8;
   localparam int unsigned RANDOM_BEATS = 1525;
   localparam int unsigned IDLE_LIMIT   = 2000;

   typedef struct {
      smm_op_type          op;
      logic [INDEX_W-1:0]  sensor_index;
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] load_low;
      logic [SAMPLE_W-1:0] load_high;
   } sensor_cmd_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [1:0]          req_op = '0;
   logic [INDEX_W-1:0]  req_sensor_index = '0;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic [SAMPLE_W-1:0] req_load_low = '0;
   logic [SAMPLE_W-1:0] req_load_high = '0;
   logic                busy;
   logic                rsp_valid;
   logic [NORM_W-1:0]   rsp_norm_value;
   logic [SAMPLE_W-1:0] rsp_low_bound;
   logic [SAMPLE_W-1:0] rsp_high_bound;
   logic [SAMPLE_W-1:0] rsp_midpoint;
   logic                rsp_calibrated;
   logic                rsp_bad_sensor;
   int unsigned         fail_count;
   int unsigned         pending;
   int unsigned         idle_cycles = 0;

   sensor_min_max_calibrate_normalize #(
      .SENSOR_COUNT(SENSORS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_sensor_index (req_sensor_index),
      .req_sample       (req_sample),
      .req_load_low     (req_load_low),
      .req_load_high    (req_load_high),
      .rsp_valid        (rsp_valid),
      .rsp_norm_value   (rsp_norm_value),
      .rsp_low_bound    (rsp_low_bound),
      .rsp_high_bound   (rsp_high_bound),
      .rsp_midpoint     (rsp_midpoint),
      .rsp_calibrated   (rsp_calibrated),
      .rsp_bad_sensor   (rsp_bad_sensor)
   );

   sensor_min_max_calibrate_normalize_checker #(
      .SENSOR_COUNT(SENSORS)
   ) bounds_check (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_sensor_index (req_sensor_index),
      .req_sample       (req_sample),
      .req_load_low     (req_load_low),
      .req_load_high    (req_load_high),
      .rsp_valid        (rsp_valid),
      .rsp_norm_value   (rsp_norm_value),
      .rsp_low_bound    (rsp_low_bound),
      .rsp_high_bound   (rsp_high_bound),
      .rsp_midpoint     (rsp_midpoint),
      .rsp_calibrated   (rsp_calibrated),
      .rsp_bad_sensor   (rsp_bad_sensor),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("sensor_min_max_calibrate_normalize: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic sensor_cmd_type make_cmd(smm_op_type op, int unsigned idx,
                                               int unsigned smp, int unsigned lo,
                                               int unsigned hi);
      sensor_cmd_type c;
      c.op           = op;
      c.sensor_index = INDEX_W'(idx);
      c.sample       = SAMPLE_W'(smp);
      c.load_low     = SAMPLE_W'(lo);
      c.load_high    = SAMPLE_W'(hi);
      return c;
   endfunction

   function automatic sensor_cmd_type random_cmd();
      sensor_cmd_type      c;
      int unsigned         pick;
      logic [SAMPLE_W-1:0] swap;
      pick = $urandom_range(0, 99);
      if (pick < 3) c.op = OP_CLEAR;
      else if (pick < 40) c.op = OP_CALIBRATE;
      else if (pick < 85) c.op = OP_NORMALIZE;
      else c.op = OP_LOAD;
      if ($urandom_range(0, 99) < 88) c.sensor_index = INDEX_W'($urandom_range(0, SENSORS - 1));
      else c.sensor_index = INDEX_W'($urandom_range(SENSORS, 15));
      c.sample    = SAMPLE_W'($urandom);
      c.load_low  = SAMPLE_W'($urandom);
      c.load_high = SAMPLE_W'($urandom);
      if (c.op == OP_CALIBRATE && $urandom_range(0, 2) == 0)
         c.sample = SAMPLE_W'($urandom_range(1900, 2200));
      if (c.op == OP_LOAD) begin
         pick = $urandom_range(0, 9);
         if (pick < 6 && c.load_low > c.load_high) begin
            swap        = c.load_low;
            c.load_low  = c.load_high;
            c.load_high = swap;
         end else if (pick < 8 && c.load_low < 4088) begin
            c.load_high = c.load_low + SAMPLE_W'($urandom_range(1, 7));
         end
      end
      return c;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 6);
      if (roll < 97) return $urandom_range(7, 20);
      return $urandom_range(21, 80);
   endfunction

   task automatic send_cmd(input sensor_cmd_type c, input bit steady);
      int unsigned gap;
      req_op           <= c.op;
      req_sensor_index <= c.sensor_index;
      req_sample       <= c.sample;
      req_load_low     <= c.load_low;
      req_load_high    <= c.load_high;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      sensor_cmd_type directed [$];
      bit             steady;
      steady = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      directed.push_back(make_cmd(OP_NORMALIZE, 0, 2048, 0, 0));
      directed.push_back(make_cmd(OP_NORMALIZE, 0, 4095, 0, 0));
      directed.push_back(make_cmd(OP_NORMALIZE, 0, 0, 0, 0));
      directed.push_back(make_cmd(OP_CALIBRATE, 7, 100, 0, 0));
      directed.push_back(make_cmd(OP_CLEAR, 3, 0, 4095, 4095));
      directed.push_back(make_cmd(OP_NORMALIZE, 3, 1000, 0, 0));
      directed.push_back(make_cmd(OP_CLEAR, 12, 4095, 0, 0));
      directed.push_back(make_cmd(OP_CALIBRATE, 0, 0, 0, 0));
      directed.push_back(make_cmd(OP_CALIBRATE, 0, 4095, 0, 0));
      directed.push_back(make_cmd(OP_NORMALIZE, 0, 4095, 0, 0));
      directed.push_back(make_cmd(OP_CALIBRATE, 1, 500, 0, 0));
      directed.push_back(make_cmd(OP_CALIBRATE, 1, 1500, 0, 0));
      directed.push_back(make_cmd(OP_NORMALIZE, 1, 400, 0, 0));
      directed.push_back(make_cmd(OP_NORMALIZE, 1, 500, 0, 0));
      directed.push_back(make_cmd(OP_NORMALIZE, 1, 1000, 0, 0));
      directed.push_back(make_cmd(OP_NORMALIZE, 1, 1500, 0, 0));
      directed.push_back(make_cmd(OP_NORMALIZE, 1, 3000, 0, 0));
      directed.push_back(make_cmd(OP_LOAD, 2, 0, 4095, 0));
      directed.push_back(make_cmd(OP_NORMALIZE, 2, 2000, 0, 0));
      directed.push_back(make_cmd(OP_LOAD, 2, 0, 800, 800));
      directed.push_back(make_cmd(OP_LOAD, 2, 0, 1000, 1001));
      directed.push_back(make_cmd(OP_NORMALIZE, 2, 1001, 0, 0));
      directed.push_back(make_cmd(OP_NORMALIZE, 2, 4095, 0, 0));
      directed.push_back(make_cmd(OP_LOAD, 15, 0, 1, 2));
      directed.push_back(make_cmd(OP_CALIBRATE, 8, 5, 0, 0));
      directed.push_back(make_cmd(OP_NORMALIZE, 9, 3000, 0, 0));
      directed.push_back(make_cmd(OP_LOAD, 7, 0, 0, 4095));

      foreach (directed[i]) send_cmd(directed[i], 1'b0);

      for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
         send_cmd(random_cmd(), steady);
      end
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("sensor_min_max_calibrate_normalize: match");
      end else begin
         $display("sensor_min_max_calibrate_normalize: mismatch");
      end
      $finish;
   end

endmodule

[sensor_min_max_calibrate_normalize.f]
+incdir+hw/rtl
hw/rtl/smm_pkg.sv
hw/rtl/smm_datapath.sv
hw/rtl/smm_controller.sv
hw/rtl/sensor_min_max_calibrate_normalize.sv
tb/sensor_min_max_calibrate_normalize_checker.sv
tb/tb.sv
